[src/prld_pkg.sv]
// shared types and constants for the pcx run-length line decoder
// no dependencies; imported by prld_ctrl, prld_datapath and the top level
package prld_pkg;

  localparam logic [7:0] RUN_MARK = 8'hc0;
  localparam logic [7:0] RUN_MASK = 8'h3f;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_POSITIONS = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input byte transfer this cycle
    logic step;    // decode one position of the current run
    logic flush;   // push held result out, marked last
  } prld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic starts_run;    // byte at input produces positions
    logic run_done;      // no positions left for this byte
    logic step_blocked;  // a visible step would find the output full
    logic hold_valid;    // a result waits in the hold register
    logic out_free;      // output register can take a result this cycle
    logic finished;      // decoding has stopped
  } prld_sts_t;

endpackage

[src/prld_ctrl.sv]
// controller state machine of the pcx run-length line decoder
// depends on prld_pkg for the command and status structs
module prld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prld_pkg::prld_sts_t sts_i,
  output prld_pkg::prld_cmd_t cmd_o
);
  import prld_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.starts_run) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts_i.run_done) begin
          state_d = ST_FLUSH;
        end else if (!sts_i.step_blocked) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.hold_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/prld_datapath.sv]
// datapath of the pcx run-length line decoder: config registers, decode state,
// column and position counters, hold and output registers; depends on prld_pkg
module prld_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [prld_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [31:0]                            cfg_data_i,
  input  logic [7:0]                             encoded_byte_i,
  input  prld_pkg::prld_cmd_t                    cmd_i,
  output prld_pkg::prld_sts_t                    sts_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [7:0]                             pixel_o,
  output logic                                   run_last_o,
  output logic                                   image_done_o
);
  import prld_pkg::*;

  logic [15:0] line_stride_q, image_width_q;
  logic [31:0] total_q;

  logic        expect_q, finished_q;
  logic [5:0]  pending_q, count_q;
  logic [15:0] column_q;
  logic [31:0] position_q;
  logic [7:0]  value_q;

  logic        hold_valid_q, hold_done_q;
  logic [7:0]  hold_pixel_q;

  logic        out_valid_q, out_last_q, out_done_q;
  logic [7:0]  out_pixel_q;

  logic        stop, is_header, visible, out_free, push;
  logic [15:0] col_inc, col_next;
  logic [31:0] pos_inc;

  assign stop      = finished_q || !(position_q < total_q);
  assign is_header = !(encoded_byte_i < RUN_MARK);
  assign visible   = column_q < image_width_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign col_inc  = column_q + 16'd1;
  assign col_next = ((line_stride_q != 16'd0) && !(col_inc < line_stride_q)) ? 16'd0 : col_inc;
  assign pos_inc  = position_q + 32'd1;

  // held result leaves when a later visible one appears, or at the end marked last
  assign push = cmd_i.flush || (cmd_i.step && visible && hold_valid_q);

  always_comb begin
    sts_o.starts_run   = !stop && (expect_q || !is_header);
    sts_o.run_done     = (count_q == 6'd0) || finished_q;
    sts_o.step_blocked = visible && hold_valid_q && !out_free;
    sts_o.hold_valid   = hold_valid_q;
    sts_o.out_free     = out_free;
    sts_o.finished     = finished_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_stride_q <= 16'd1;
      image_width_q <= 16'd1;
      total_q       <= '0;
      expect_q      <= 1'b0;
      pending_q     <= '0;
      count_q       <= '0;
      column_q      <= '0;
      position_q    <= '0;
      finished_q    <= 1'b0;
      hold_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LINE_STRIDE:     line_stride_q <= cfg_data_i[15:0];
          CFG_IMAGE_WIDTH:     image_width_q <= cfg_data_i[15:0];
          CFG_TOTAL_POSITIONS: total_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (stop) begin
          finished_q <= 1'b1;
        end else if (expect_q) begin
          expect_q  <= 1'b0;
          count_q   <= pending_q;
          pending_q <= '0;
        end else if (is_header) begin
          expect_q  <= 1'b1;
          pending_q <= encoded_byte_i[5:0] & RUN_MASK[5:0];
        end else begin
          count_q <= 6'd1;
        end
      end
      if (cmd_i.step) begin
        count_q    <= count_q - 6'd1;
        column_q   <= col_next;
        position_q <= pos_inc;
        if (!(pos_inc < total_q)) begin
          finished_q <= 1'b1;
        end
        if (visible) begin
          hold_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        hold_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= encoded_byte_i;
    end
    if (cmd_i.step && visible) begin
      hold_pixel_q <= value_q;
      hold_done_q  <= (pos_inc == total_q);
    end
    if (push) begin
      out_pixel_q <= hold_pixel_q;
      out_done_q  <= hold_done_q;
      out_last_q  <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_o      = out_pixel_q;
  assign run_last_o   = out_last_q;
  assign image_done_o = out_done_q;

endmodule

[src/pcx_rle_line_decoder.sv]
// top level of the pcx run-length line decoder
// instantiates prld_ctrl and prld_datapath; depends on prld_pkg
//
// usage
// - input channel: one compressed byte per transfer on encoded_byte_i, taken
//   when in_valid_i is high and in_stall_o is low
// - output channel: one visible pixel per transfer with run_last_o on the last
//   result of a byte and image_done_o on the one that reaches the total
// - config channel: cfg_index_i selects line stride, image width or total
//   positions; written when cfg_valid_i and cfg_ready_o are both high, only
//   while the block is idle
// - a header byte never holds the input off; a literal or a run value byte
//   holds it off while the run steps through its positions, makes the end
//   test and flushes the held result, longer under stall
// - each visible result waits in the hold register until a later visible step
//   or the flush shows whether it is the last; the lone result of a literal
//   leaves with the flush
// - a stalled output holds its result; the run loop pauses only when a new
//   visible pixel would need the full output register
// - reset restores stride 1, width 1, total 0 and clears all decode state
module pcx_rle_line_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prld_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  // compressed input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        encoded_byte_i,
  // decoded pixels
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        pixel_o,
  output logic                              run_last_o,
  output logic                              image_done_o
);
  import prld_pkg::*;

  prld_cmd_t cmd;
  prld_sts_t sts;

  // registers change only between bytes, so accept writes while idle
  assign cfg_ready_o = !in_stall_o;

  prld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prld_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .encoded_byte_i (encoded_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_o        (pixel_o),
    .run_last_o     (run_last_o),
    .image_done_o   (image_done_o)
  );

`ifndef SYNTH
  // only one command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.step, cmd.flush}))
    else $error("more than one datapath command");

  // no result may be left in the hold register once a new byte can arrive
  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.hold_valid)
    else $error("held result left behind at idle");

  // stopping is sticky until reset
  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.finished |=> sts.finished)
    else $error("finished flag cleared");

  // a flush always lands in the output register marked last
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> (out_valid_o && run_last_o))
    else $error("flush did not deliver a last result");
`endif

endmodule
